>>> hw/rtl/piecewise_linear_evaluator_assert.svh
// Assertion helpers; every user has a clock i_clk and reset i_rst_n.
`ifndef PIECEWISE_LINEAR_EVALUATOR_ASSERT_SVH
`define PIECEWISE_LINEAR_EVALUATOR_ASSERT_SVH

`define PWL_ASSERT_ALWAYS(label, expr) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (expr)) \
        else $error("pwl assertion failed");

`define PWL_ASSERT_IMPLY(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("pwl assertion failed");

`endif

>>> hw/rtl/pwl_pkg.sv
package pwl_pkg;

    localparam int MAX_POINTS_DEF = 16;
    localparam int DIV_STEPS      = 16;
    localparam int CFG_IDX_W      = 1;

    localparam logic [CFG_IDX_W-1:0] CFG_CLAMP = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ERROR = 1'd1;

    typedef enum logic [1:0] {
        OP_CLEAR  = 2'd0,
        OP_APPEND = 2'd1,
        OP_EVAL   = 2'd2,
        OP_NOP    = 2'd3
    } t_op;

    typedef enum logic [2:0] {
        ST_INTERP    = 3'd0,
        ST_CLAMP_LO  = 3'd1,
        ST_CLAMP_HI  = 3'd2,
        ST_OUT_RANGE = 3'd3,
        ST_INVALID   = 3'd4,
        ST_ACK       = 3'd5,
        ST_FULL      = 3'd6
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_READ,
        S_CMP,
        S_DIV,
        S_MUL,
        S_ADD
    } t_state;

    typedef struct packed {
        t_op                op;
        logic signed [31:0] x;
        logic signed [31:0] y;
    } t_item;

endpackage

>>> hw/rtl/pwl_ram.sv
module pwl_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> hw/rtl/pwl_front.sv
module pwl_front import pwl_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [1:0]  i_func,
    input  logic [31:0] i_x_value,
    input  logic [31:0] i_y_value,
    input  logic        i_q_full,
    output logic        o_push,
    output t_item       o_item
);

    logic  r_valid, n_valid;
    t_item r_item, n_item;
    logic  accept;

    assign o_stall = r_valid && i_q_full;
    assign accept  = i_valid && !o_stall;
    assign o_push  = r_valid && !i_q_full;
    assign o_item  = r_item;

    always_comb begin
        n_item   = r_item;
        n_valid  = o_push ? 1'b0 : r_valid;
        if (accept) begin
            n_valid  = 1'b1;
            n_item.x = i_x_value;
            n_item.y = i_y_value;
            case (i_func)
                OP_CLEAR:  n_item.op = OP_CLEAR;
                OP_APPEND: n_item.op = OP_APPEND;
                OP_EVAL:   n_item.op = OP_EVAL;
                default:   n_item.op = OP_NOP;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
        r_item <= n_item;
    end

endmodule

>>> hw/rtl/pwl_queue.sv
module pwl_queue import pwl_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_push,
    input  t_item i_item,
    output logic  o_full,
    input  logic  i_pop,
    output logic  o_valid,
    output t_item o_item
);

    t_item      r_slot [2];
    logic       r_wptr, r_rptr;
    logic [1:0] r_cnt;

    assign o_full  = r_cnt == 2'd2;
    assign o_valid = r_cnt != 2'd0;
    assign o_item  = r_slot[r_rptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= 1'b0;
            r_rptr <= 1'b0;
            r_cnt  <= 2'd0;
        end else begin
            if (i_push) begin
                r_wptr <= ~r_wptr;
            end
            if (i_pop) begin
                r_rptr <= ~r_rptr;
            end
            r_cnt <= r_cnt + {1'b0, i_push} - {1'b0, i_pop};
        end
        if (i_push) begin
            r_slot[r_wptr] <= i_item;
        end
    end

endmodule

>>> hw/rtl/pwl_back.sv
module pwl_back import pwl_pkg::*; #(
    parameter int MAX_POINTS = MAX_POINTS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_q_valid,
    input  t_item       i_q_item,
    output logic        o_q_pop,
    input  logic        i_clamp_en,
    input  logic [31:0] i_err_val,
    input  logic        i_out_stall,
    output logic        o_out_valid,
    output logic [31:0] o_result,
    output logic [2:0]  o_status,
    output logic        o_table_valid
);
    `include "piecewise_linear_evaluator_assert.svh"

    localparam int AW = $clog2(MAX_POINTS);
    localparam int CW = $clog2(MAX_POINTS + 1);

    t_state r_state, n_state;

    logic [CW-1:0]      r_count, n_count;
    logic               r_broken, n_broken;
    logic [1:0]         r_run, n_run;
    logic signed [31:0] r_first_x, r_first_y, r_last_x, r_last_y;
    logic signed [31:0] r_x, r_px, r_py, r_cy;
    logic [AW-1:0]      r_idx;
    logic [33:0]        r_rem;
    logic [32:0]        r_span;
    logic [16:0]        r_q;
    logic [3:0]         r_step;
    logic signed [50:0] r_prod;

    logic               r_ovalid, r_tv;
    logic [31:0]        r_res;
    t_status            r_stat;

    logic               free, ok, is_long, tbl_full;
    logic [31:0]        s_res;
    t_status            s_stat;
    logic               s_tv;
    logic               ram_we, out_load;
    logic [63:0]        ram_rdata;
    logic signed [31:0] rd_x, rd_y;
    logic signed [32:0] cmp_span, cmp_d, dy;
    logic [33:0]        rem2;
    logic signed [50:0] prod_adj;
    logic [31:0]        add_res;

    assign free     = !r_ovalid || !i_out_stall;
    assign ok       = (r_count >= CW'(2)) && !r_broken;
    assign tbl_full = r_count >= CW'(MAX_POINTS);
    assign is_long  = (i_q_item.op == OP_EVAL) && ok &&
                      !(i_q_item.x < r_first_x) && !(i_q_item.x > r_last_x);

    assign rd_x     = ram_rdata[63:32];
    assign rd_y     = ram_rdata[31:0];
    assign cmp_span = {rd_x[31], rd_x} - {r_px[31], r_px};
    assign cmp_d    = {r_x[31], r_x} - {r_px[31], r_px};
    assign rem2     = {r_rem[32:0], 1'b0};
    assign dy       = {r_cy[31], r_cy} - {r_py[31], r_py};
    assign prod_adj = r_prod + (r_prod[50] ? 51'sd65535 : 51'sd0);
    assign add_res  = r_py + prod_adj[47:16];

    pwl_ram #(.WIDTH(64), .DEPTH(MAX_POINTS)) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_count[AW-1:0]),
        .i_wdata ({i_q_item.x, i_q_item.y}),
        .i_raddr (r_idx),
        .o_rdata (ram_rdata)
    );

    // short items: table update and immediate result
    always_comb begin
        n_count  = r_count;
        n_broken = r_broken;
        n_run    = r_run;
        s_res    = 32'd0;
        s_stat   = ST_ACK;
        case (i_q_item.op)
            OP_CLEAR: begin
                n_count  = '0;
                n_broken = 1'b0;
                n_run    = 2'd1;
            end
            OP_APPEND: begin
                if (tbl_full) begin
                    s_stat = ST_FULL;
                end else begin
                    if (r_count != '0) begin
                        if (i_q_item.x < r_last_x) begin
                            n_broken = 1'b1;
                        end else if (i_q_item.x == r_last_x) begin
                            if (r_run < 2'd3) begin
                                n_run = r_run + 2'd1;
                            end
                            if (n_run > 2'd2) begin
                                n_broken = 1'b1;
                            end
                        end else begin
                            n_run = 2'd1;
                        end
                    end
                    n_count = r_count + CW'(1);
                end
            end
            OP_EVAL: begin
                if (!ok) begin
                    s_res  = i_err_val;
                    s_stat = ST_INVALID;
                end else if (i_q_item.x < r_first_x) begin
                    s_res  = i_clamp_en ? r_first_y : i_err_val;
                    s_stat = i_clamp_en ? ST_CLAMP_LO : ST_OUT_RANGE;
                end else begin
                    s_res  = i_clamp_en ? r_last_y : i_err_val;
                    s_stat = i_clamp_en ? ST_CLAMP_HI : ST_OUT_RANGE;
                end
            end
            default: ;
        endcase
        s_tv = (n_count >= CW'(2)) && !n_broken;
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: if (i_q_valid && is_long) n_state = S_READ;
            S_READ: n_state = S_CMP;
            S_CMP: begin
                if (r_x <= rd_x) begin
                    n_state = (cmp_span == '0) ? S_MUL : S_DIV;
                end else begin
                    n_state = S_READ;
                end
            end
            S_DIV:  if (r_step == 4'(DIV_STEPS - 1)) n_state = S_MUL;
            S_MUL:  n_state = S_ADD;
            S_ADD:  if (free) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_q_pop  = 1'b0;
        ram_we   = 1'b0;
        out_load = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_q_pop  = i_q_valid && (is_long || free);
                out_load = i_q_valid && !is_long && free;
                ram_we   = out_load && (i_q_item.op == OP_APPEND) && !tbl_full;
            end
            S_ADD:   out_load = free;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_count  <= '0;
            r_broken <= 1'b0;
            r_run    <= 2'd1;
            r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (out_load) begin
                r_ovalid <= 1'b1;
            end else if (!i_out_stall) begin
                r_ovalid <= 1'b0;
            end
            if (r_state == S_IDLE && out_load) begin
                r_count  <= n_count;
                r_broken <= n_broken;
                r_run    <= n_run;
            end
        end

        case (r_state)
            S_IDLE: begin
                r_x   <= i_q_item.x;
                r_px  <= r_first_x;
                r_py  <= r_first_y;
                r_idx <= AW'(1);
                if (ram_we) begin
                    if (r_count == '0) begin
                        r_first_x <= i_q_item.x;
                        r_first_y <= i_q_item.y;
                    end
                    r_last_x <= i_q_item.x;
                    r_last_y <= i_q_item.y;
                end
            end
            S_CMP: begin
                if (r_x <= rd_x) begin
                    r_cy   <= rd_y;
                    r_span <= cmp_span;
                    r_step <= '0;
                    if (cmp_span == '0) begin
                        r_q <= 17'd65536;
                    end else if (cmp_d >= cmp_span) begin
                        r_q   <= 17'd1;
                        r_rem <= {1'b0, cmp_d - cmp_span};
                    end else begin
                        r_q   <= 17'd0;
                        r_rem <= {1'b0, cmp_d};
                    end
                end else begin
                    r_px  <= rd_x;
                    r_py  <= rd_y;
                    r_idx <= r_idx + AW'(1);
                end
            end
            S_DIV: begin
                r_step <= r_step + 4'd1;
                if (rem2 >= {1'b0, r_span}) begin
                    r_rem <= rem2 - {1'b0, r_span};
                    r_q   <= {r_q[15:0], 1'b1};
                end else begin
                    r_rem <= rem2;
                    r_q   <= {r_q[15:0], 1'b0};
                end
            end
            S_MUL: r_prod <= dy * $signed({1'b0, r_q});
            default: ;
        endcase

        if (out_load) begin
            if (r_state == S_ADD) begin
                r_res  <= add_res;
                r_stat <= ST_INTERP;
                r_tv   <= 1'b1;
            end else begin
                r_res  <= s_res;
                r_stat <= s_stat;
                r_tv   <= s_tv;
            end
        end
    end

    assign o_out_valid   = r_ovalid;
    assign o_result      = r_res;
    assign o_status      = r_stat;
    assign o_table_valid = r_tv;

    `PWL_ASSERT_ALWAYS(a_count_max, r_count <= CW'(MAX_POINTS))
    `PWL_ASSERT_IMPLY(a_pop_valid, o_q_pop, i_q_valid)
    `PWL_ASSERT_IMPLY(a_div_rem, r_state == S_DIV, r_rem < {1'b0, r_span})
    `PWL_ASSERT_IMPLY(a_long_ok, r_state != S_IDLE, ok)

endmodule

>>> hw/rtl/piecewise_linear_evaluator.sv
// Clear, append, nop and out-of-range or invalid evaluate: front register, queue slot, output register.
// Interpolating evaluate: a read and a compare per breakpoint scanned, 17-bit quotient
//   (1 + 16 steps), multiply, add; a zero-width segment skips the divider.
// Throughput: one transaction per cycle for short ops while the output is not stalled; the
//   back end holds off the queue until an interpolation has produced its result.
module piecewise_linear_evaluator import pwl_pkg::*; #(
    parameter int MAX_POINTS = MAX_POINTS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_stall,
    input  logic [1:0]           i_func,
    input  logic [31:0]          i_x_value,
    input  logic [31:0]          i_y_value,
    output logic                 o_valid,
    input  logic                 i_stall,
    output logic [31:0]          o_result_value,
    output logic [2:0]           o_status,
    output logic                 o_table_valid,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [31:0]          i_cfg_data
);

    // Reset (synchronous, active low) empties the table, clamping on, error value zero.
    logic        r_clamp_en;
    logic [31:0] r_err_val;
    logic        q_full, push, pop, q_valid;
    t_item       f_item, q_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clamp_en <= 1'b1;
            r_err_val  <= 32'd0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_CLAMP: r_clamp_en <= i_cfg_data[0];
                CFG_ERROR: r_err_val  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    pwl_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_valid),
        .o_stall   (o_stall),
        .i_func    (i_func),
        .i_x_value (i_x_value),
        .i_y_value (i_y_value),
        .i_q_full  (q_full),
        .o_push    (push),
        .o_item    (f_item)
    );

    pwl_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_item  (f_item),
        .o_full  (q_full),
        .i_pop   (pop),
        .o_valid (q_valid),
        .o_item  (q_item)
    );

    pwl_back #(.MAX_POINTS(MAX_POINTS)) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_q_valid     (q_valid),
        .i_q_item      (q_item),
        .o_q_pop       (pop),
        .i_clamp_en    (r_clamp_en),
        .i_err_val     (r_err_val),
        .i_out_stall   (i_stall),
        .o_out_valid   (o_valid),
        .o_result      (o_result_value),
        .o_status      (o_status),
        .o_table_valid (o_table_valid)
    );

endmodule

>>> dv/tb.sv
module tb;
    import pwl_pkg::*;

    localparam int NPTS = MAX_POINTS_DEF;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_stall;
    logic [1:0]  i_func;
    logic [31:0] i_x_value;
    logic [31:0] i_y_value;
    logic        o_valid;
    logic        i_stall;
    logic [31:0] o_result_value;
    logic [2:0]  o_status;
    logic        o_table_valid;
    logic        i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_idx;
    logic [31:0] i_cfg_data;

    piecewise_linear_evaluator i_dut (.*);

    typedef struct {
        logic [31:0] value;
        t_status     status;
        logic        valid;
    } t_answer;

    t_item   pending_items[$];
    t_answer expected_answers[$];

    // predictor state
    logic signed [31:0] bp_x[NPTS];
    logic signed [31:0] bp_y[NPTS];
    int unsigned        bp_count;
    bit                 bp_broken;
    int unsigned        bp_run;
    bit                 cfg_clamp;
    logic signed [31:0] cfg_err;

    int  error_count;
    int  hold_cycles;
    int  n_sent;
    bit  in_taken;

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("mismatch %s: got %h want %h", what, got, want);
        error_count++;
    endtask

    function automatic bit table_is_valid();
        return bp_count >= 2 && !bp_broken;
    endfunction

    function automatic t_answer predict_answer(t_item it);
        t_answer a;
        longint x0, span, t, y0, y1, xq;
        int unsigned last;
        a.value = '0;
        a.status = ST_ACK;
        xq = it.x;
        case (it.op)
            OP_CLEAR: begin
                bp_count = 0;
                bp_broken = 0;
                bp_run = 1;
            end
            OP_APPEND: begin
                if (bp_count >= NPTS) begin
                    a.status = ST_FULL;
                end else begin
                    if (bp_count > 0) begin
                        if (it.x < bp_x[bp_count-1]) begin
                            bp_broken = 1;
                        end else if (it.x == bp_x[bp_count-1]) begin
                            if (bp_run < 3) bp_run++;
                            if (bp_run > 2) bp_broken = 1;
                        end else begin
                            bp_run = 1;
                        end
                    end
                    bp_x[bp_count] = it.x;
                    bp_y[bp_count] = it.y;
                    bp_count++;
                end
            end
            OP_EVAL: begin
                if (!table_is_valid()) begin
                    a.value = cfg_err;
                    a.status = ST_INVALID;
                end else begin
                    last = bp_count - 1;
                    if (xq < bp_x[0]) begin
                        a.value = cfg_clamp ? bp_y[0] : cfg_err;
                        a.status = cfg_clamp ? ST_CLAMP_LO : ST_OUT_RANGE;
                    end else if (xq > bp_x[last]) begin
                        a.value = cfg_clamp ? bp_y[last] : cfg_err;
                        a.status = cfg_clamp ? ST_CLAMP_HI : ST_OUT_RANGE;
                    end else begin
                        for (int i = 1; i <= last; i++) begin
                            if (xq <= bp_x[i]) begin
                                x0 = bp_x[i-1];
                                span = longint'(bp_x[i]) - x0;
                                t = 65536;
                                if (span > 0) t = ((xq - x0) <<< 16) / span;
                                y0 = bp_y[i-1];
                                y1 = bp_y[i];
                                a.value = 32'(y0 + ((y1 - y0) * t) / 65536);
                                a.status = ST_INTERP;
                                break;
                            end
                        end
                    end
                end
            end
            default: ;
        endcase
        a.valid = table_is_valid();
        return a;
    endfunction

    initial begin
        i_clk = 0;
        forever #2 i_clk = ~i_clk;
    end

    // input handshake as seen at the rising edge
    always @(posedge i_clk) begin
        in_taken = i_rst_n && i_valid && !o_stall;
    end

    // driver
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 0;
        end else begin
            if (in_taken) begin
                expected_answers.push_back(predict_answer(pending_items.pop_front()));
                n_sent++;
            end
            if (i_valid && !in_taken) begin
            end else if (pending_items.size() > 0 && ($urandom_range(0, 3) != 0)) begin
                i_valid   <= 1;
                i_func    <= pending_items[0].op;
                i_x_value <= pending_items[0].x;
                i_y_value <= pending_items[0].y;
            end else begin
                i_valid <= 0;
            end
        end
    end

    // sender side: at negedge the accepted item is still at head of queue
    // (predicted at next negedge after edge). Gaps between items come from the driver's random idle choice.

    // receiver stall
    always @(negedge i_clk) begin
        if (hold_cycles > 0) begin
            i_stall <= 1;
            hold_cycles--;
        end else if ($urandom_range(0, 199) == 0) begin
            hold_cycles = $urandom_range(10, 60);
            i_stall <= 1;
        end else if ($urandom_range(0, 9) == 0) i_stall <= 1;
        else i_stall <= ($urandom_range(0, 31) == 0) ? 1'b1 : 1'b0;
    end

    // monitor
    always @(posedge i_clk) begin
        t_answer e;
        if (i_rst_n && o_valid && !i_stall) begin
            if (expected_answers.size() == 0) begin
                report_mismatch("unexpected transaction", o_result_value, '0);
            end else begin
                e = expected_answers.pop_front();
                if (o_result_value !== e.value)
                    report_mismatch("result_value", o_result_value, e.value);
                if (o_status !== e.status)
                    report_mismatch("status", 32'(o_status), 32'(e.status));
                if (o_table_valid !== e.valid)
                    report_mismatch("table_valid", 32'(o_table_valid), 32'(e.valid));
            end
        end
    end

    function automatic logic [31:0] rand_word();
        case ($urandom_range(0, 5))
            0: return 32'h8000_0000;
            1: return 32'h7fff_ffff;
            2: return 32'(int'($urandom_range(0, 2000)) - 1000) <<< 8;
            default: return $urandom();
        endcase
    endfunction

    function automatic t_item mk(t_op op, logic [31:0] x, logic [31:0] y);
        t_item it;
        it.op = op;
        it.x = x;
        it.y = y;
        return it;
    endfunction

    task automatic wait_drained();
        while (pending_items.size() > 0 || i_valid || expected_answers.size() > 0)
            @(posedge i_clk);
        repeat (80) @(posedge i_clk);
    endtask

    task automatic write_cfg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] d);
        @(negedge i_clk);
        i_cfg_we <= 1;
        i_cfg_idx <= idx;
        i_cfg_data <= d;
        @(negedge i_clk);
        i_cfg_we <= 0;
        if (idx == CFG_CLAMP) cfg_clamp = d[0];
        else cfg_err = d;
    endtask

    // table: sorted inputs with occasional repeated x, out-of-order steps when allow_bad is set
    task automatic queue_table(input int n, input bit allow_bad);
        logic signed [31:0] x;
        int span;
        span = $urandom_range(0, 3) == 0 ? 32'h1000_0000 : 32'h0004_0000;
        pending_items.push_back(mk(OP_CLEAR, $urandom(), $urandom()));
        x = -span * $urandom_range(1, 8);
        if ($urandom_range(0, 9) == 0) x = 32'sh8000_0000;
        for (int i = 0; i < n; i++) begin
            pending_items.push_back(mk(OP_APPEND, x, rand_word()));
            if (allow_bad && $urandom_range(0, 7) == 0) x = x - $urandom_range(1, 100);
            else if ($urandom_range(0, 5) != 0) begin
                if (x > 32'sh7000_0000) x = 32'sh7fff_ffff;
                else x = x + $urandom_range(1, span);
            end
        end
    endtask

    function automatic logic [31:0] bp_pick();
        t_item it;
        for (int k = pending_items.size() - 1; k >= 0; k--) begin
            it = pending_items[k];
            if (it.op == OP_APPEND && $urandom_range(0, 2) == 0) return it.x;
            if (it.op == OP_CLEAR) break;
        end
        return $urandom();
    endfunction

    task automatic queue_queries(input int n);
        for (int i = 0; i < n; i++) begin
            if ($urandom_range(0, 19) == 0)
                pending_items.push_back(mk(t_op'($urandom_range(0, 3)), rand_word(),
                                           rand_word()));
            else if ($urandom_range(0, 4) == 0)
                pending_items.push_back(mk(OP_EVAL, rand_word(), $urandom()));
            else
                pending_items.push_back(mk(OP_EVAL,
                    bp_pick() + int'($urandom_range(0, 32'h0008_0000)) - 32'sh0004_0000,
                    $urandom()));
        end
    endtask

    initial begin
        i_rst_n = 0;
        i_valid = 0;
        i_stall = 0;
        i_func = OP_NOP;
        i_x_value = 0;
        i_y_value = 0;
        i_cfg_we = 0;
        i_cfg_idx = CFG_CLAMP;
        i_cfg_data = 0;
        error_count = 0;
        hold_cycles = 0;
        n_sent = 0;
        in_taken = 0;
        bp_count = 0;
        bp_broken = 0;
        bp_run = 1;
        cfg_clamp = 1;
        cfg_err = 0;
        for (int i = 0; i < NPTS; i++) begin
            bp_x[i] = 0;
            bp_y[i] = 0;
        end
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1;

        // directed: invalid table, extremes, zero-width segment, full, nop
        pending_items.push_back(mk(OP_EVAL, 0, 0));
        pending_items.push_back(mk(OP_APPEND, 32'h8000_0000, 32'h7fff_ffff));
        pending_items.push_back(mk(OP_EVAL, 0, 0));
        pending_items.push_back(mk(OP_APPEND, 0, 32'h8000_0000));
        pending_items.push_back(mk(OP_APPEND, 0, 32'h0001_0000));
        pending_items.push_back(mk(OP_APPEND, 32'h7fff_ffff, 32'h8000_0000));
        pending_items.push_back(mk(OP_EVAL, 0, 0));
        pending_items.push_back(mk(OP_EVAL, 32'h8000_0000, 0));
        pending_items.push_back(mk(OP_EVAL, 32'h7fff_ffff, 0));
        pending_items.push_back(mk(OP_EVAL, 32'hc000_0000, 0));
        pending_items.push_back(mk(OP_EVAL, 32'h4000_0000, 0));
        pending_items.push_back(mk(OP_NOP, 32'hffff_ffff, 32'hffff_ffff));
        pending_items.push_back(mk(OP_APPEND, 32'h7fff_ffff, 5));
        pending_items.push_back(mk(OP_APPEND, 32'h7fff_ffff, 6));
        pending_items.push_back(mk(OP_EVAL, 32'h7fff_ffff, 0));
        pending_items.push_back(mk(OP_CLEAR, 0, 0));
        for (int i = 0; i < 17; i++)
            pending_items.push_back(mk(OP_APPEND, i <<< 16, i * 3));
        pending_items.push_back(mk(OP_EVAL, 32'h000f_8000, 0));
        pending_items.push_back(mk(OP_EVAL, 32'hffff_0000, 0));
        wait_drained();

        write_cfg(CFG_CLAMP, 0);
        write_cfg(CFG_ERROR, 32'h8000_0000);
        pending_items.push_back(mk(OP_EVAL, 32'hffff_0000, 0));
        pending_items.push_back(mk(OP_EVAL, 32'h0020_0000, 0));
        pending_items.push_back(mk(OP_APPEND, 0, 0));
        pending_items.push_back(mk(OP_EVAL, 32'h0001_0000, 0));

        // stall the receiver long while items keep coming
        queue_table(4, 0);
        queue_queries(30);
        hold_cycles = 400;
        wait (hold_cycles == 0);
        wait_drained();

        for (int ph = 0; ph < 10; ph++) begin
            case (ph % 4)
                0: write_cfg(CFG_CLAMP, 1);
                1: write_cfg(CFG_ERROR, 32'h7fff_ffff);
                2: write_cfg(CFG_CLAMP, 0);
                default: write_cfg(CFG_ERROR, $urandom());
            endcase
            for (int k = 0; k < 6; k++) begin
                queue_table($urandom_range(0, 3) == 0 ? $urandom_range(0, 17)
                                                     : $urandom_range(2, 6),
                            $urandom_range(0, 4) == 0);
                queue_queries($urandom_range(5, 12));
                while (pending_items.size() > 4) @(posedge i_clk);
                if ($urandom_range(0, 5) == 0) repeat ($urandom_range(20, 120)) @(posedge i_clk);
            end
            wait_drained();
        end

        if (error_count == 0) $display("SUCCESS");
        else $display("FAILURE");
        $finish;
    end

    initial begin
        #4000000;
        $display("FAILURE");
        $finish;
    end
endmodule

>>> piecewise_linear_evaluator.f
+incdir+hw/rtl
hw/rtl/pwl_pkg.sv
hw/rtl/pwl_ram.sv
hw/rtl/pwl_front.sv
hw/rtl/pwl_queue.sv
hw/rtl/pwl_back.sv
hw/rtl/piecewise_linear_evaluator.sv
dv/tb.sv
